FILE: rtl/dbd_pkg.sv
`timescale 1ns / 1ps

package dbd_pkg;

  localparam int DAY_W   = 7;
  localparam int MONTH_W = 7;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 22;
  localparam int ERR_W   = 2;
  // day number width; an invalid year can reach past the 22-bit count range
  localparam int DNUM_W  = 23;
  localparam int QUO_W   = 8;   // year / 100 for years up to 16383
  localparam int OFF_W   = 9;   // day of year, 1..366
  localparam int MLEN_W  = 5;

  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 7'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 7'd12;

  // x / 25 == (x * 1311) >> 15 for x below 4096
  localparam logic [10:0] RECIP_25    = 11'd1311;
  localparam int          RECIP_SHIFT = 15;
  localparam int          PROD_W      = 23;

  localparam int ERR_FIRST  = 0;
  localparam int ERR_SECOND = 1;

  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [YEAR_W-1:0]  year_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [ERR_W-1:0]   err_t;
  typedef logic [DNUM_W-1:0]  dnum_t;

  // stage load enables handed to each lane
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } lane_ctrl_t;

  function automatic logic [OFF_W-1:0] days_before(input month_t m);
    logic [OFF_W-1:0] r;
    case (m)
      7'd2:    r = 9'd31;
      7'd3:    r = 9'd59;
      7'd4:    r = 9'd90;
      7'd5:    r = 9'd120;
      7'd6:    r = 9'd151;
      7'd7:    r = 9'd181;
      7'd8:    r = 9'd212;
      7'd9:    r = 9'd243;
      7'd10:   r = 9'd273;
      7'd11:   r = 9'd304;
      7'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [MLEN_W-1:0] month_len(input month_t m, input logic leap);
    logic [MLEN_W-1:0] r;
    case (m)
      7'd2:                      r = leap ? 5'd29 : 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/dbd_in_if.sv
`timescale 1ns / 1ps

interface dbd_in_if;
  import dbd_pkg::*;

  logic   valid;
  logic   ready;
  day_t   first_day;
  month_t first_month;
  year_t  first_year;
  day_t   second_day;
  month_t second_month;
  year_t  second_year;

  modport source (
    output valid, first_day, first_month, first_year,
           second_day, second_month, second_year,
    input  ready
  );

  modport sink (
    input  valid, first_day, first_month, first_year,
           second_day, second_month, second_year,
    output ready
  );
endinterface

FILE: rtl/dbd_out_if.sv
`timescale 1ns / 1ps

interface dbd_out_if;
  import dbd_pkg::*;

  logic   valid;
  logic   ready;
  count_t day_count;
  err_t   date_error;
  logic   second_is_earlier;

  modport source (
    output valid, day_count, date_error, second_is_earlier,
    input  ready
  );

  modport sink (
    input  valid, day_count, date_error, second_is_earlier,
    output ready
  );
endinterface

FILE: rtl/dbd_lane.sv
`timescale 1ns / 1ps

// One date: validity check and day number (0001-01-01 = 1), three stages.
module dbd_lane (
  input  logic               clk,
  input  dbd_pkg::lane_ctrl_t ctrl,
  input  dbd_pkg::day_t      day,
  input  dbd_pkg::month_t    month,
  input  dbd_pkg::year_t     year,
  output dbd_pkg::dnum_t     day_num,
  output logic               ok
);
  import dbd_pkg::*;

  // stage 1: year - 1 and the two divisions by 100
  year_t              p_in;
  logic [PROD_W-1:0]  prod_y;
  logic [PROD_W-1:0]  prod_p;

  day_t               s1_d;
  month_t             s1_m;
  year_t              s1_y;
  year_t              s1_p;
  logic [QUO_W-1:0]   s1_qy;
  logic [QUO_W-1:0]   s1_qp;

  assign p_in   = year - YEAR_W'(1);
  assign prod_y = PROD_W'(year[YEAR_W-1:2]) * PROD_W'(RECIP_25);
  assign prod_p = PROD_W'(p_in[YEAR_W-1:2]) * PROD_W'(RECIP_25);

  always_ff @(posedge clk) begin
    if (ctrl.ld1) begin
      s1_d  <= day;
      s1_m  <= month;
      s1_y  <= year;
      s1_p  <= p_in;
      s1_qy <= prod_y[RECIP_SHIFT +: QUO_W];
      s1_qp <= prod_p[RECIP_SHIFT +: QUO_W];
    end
  end

  // stage 2: leap rule, validity, year base and day-of-year offset
  logic               leap;
  logic [YEAR_W-3:0]  qy_x25;
  logic               ok_c;
  dnum_t              base_c;
  logic [OFF_W-1:0]   off_c;

  dnum_t              s2_base;
  logic [OFF_W-1:0]   s2_off;
  logic               s2_ok;

  assign qy_x25 = (YEAR_W-2)'(s1_qy) * (YEAR_W-2)'(25);
  // divisible by 4, and either not by 100 or the century divisible by 4
  assign leap = (s1_y[1:0] == 2'b00) &&
                ((s1_y[YEAR_W-1:2] != qy_x25) || (s1_qy[1:0] == 2'b00));

  assign ok_c = (s1_y != '0) && (s1_y <= YEAR_MAX) && (s1_d != '0) &&
                (s1_m != '0) && (s1_m <= MONTH_DEC) &&
                (s1_d <= DAY_W'(month_len(s1_m, leap)));

  assign base_c = DNUM_W'(s1_p) * DNUM_W'(365) + DNUM_W'(s1_p[YEAR_W-1:2])
                - DNUM_W'(s1_qp) + DNUM_W'(s1_qp[QUO_W-1:2]);

  assign off_c = days_before(s1_m) + OFF_W'(leap && (s1_m > MONTH_FEB))
               + OFF_W'(s1_d[MLEN_W-1:0]);

  always_ff @(posedge clk) begin
    if (ctrl.ld2) begin
      s2_base <= base_c;
      s2_off  <= off_c;
      s2_ok   <= ok_c;
    end
  end

  // stage 3: final day number
  always_ff @(posedge clk) begin
    if (ctrl.ld3) begin
      day_num <= s2_base + DNUM_W'(s2_off);
      ok      <= s2_ok;
    end
  end

endmodule

FILE: rtl/dbd_merge.sv
`timescale 1ns / 1ps

// Combines both lanes: error code, ordering and absolute difference.
module dbd_merge (
  input  logic            clk,
  input  logic            load,
  input  dbd_pkg::dnum_t  num_first,
  input  logic            ok_first,
  input  dbd_pkg::dnum_t  num_second,
  input  logic            ok_second,
  output dbd_pkg::count_t day_count,
  output dbd_pkg::err_t   date_error,
  output logic            second_is_earlier
);
  import dbd_pkg::*;

  logic  both_ok;
  logic  sec_lt;
  dnum_t diff_fs;
  dnum_t diff_sf;

  assign both_ok = ok_first && ok_second;
  assign sec_lt  = num_second < num_first;
  assign diff_fs = num_first - num_second;
  assign diff_sf = num_second - num_first;

  always_ff @(posedge clk) begin
    if (load) begin
      date_error[ERR_FIRST]  <= !ok_first;
      date_error[ERR_SECOND] <= !ok_second;
      if (!both_ok) begin
        day_count         <= '0;
        second_is_earlier <= 1'b0;
      end else begin
        second_is_earlier <= sec_lt;
        day_count         <= sec_lt ? diff_fs[COUNT_W-1:0] : diff_sf[COUNT_W-1:0];
      end
    end
  end

endmodule

FILE: rtl/days_between_dates.sv
// Pipeline: 3 lane stages plus the merge stage, which is the output register.
// Throughput: one request per cycle unless stalled; each stage advances when the
// stage after it is empty or moving, so bubbles close up while the output is stalled.
// Reset (rst, synchronous) clears only the stage valid bits; data registers
// are not reset.
`timescale 1ns / 1ps

module days_between_dates (
  input  logic       clk,
  input  logic       rst,
  dbd_in_if.sink     request,
  dbd_out_if.source  result
);
  import dbd_pkg::*;

  // stage valid bits; v4 is the output register
  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;

  lane_ctrl_t ctrl;

  dnum_t num_first, num_second;
  logic  ok_first, ok_second;

  // ready chain from the output back toward the input
  assign adv4 = !v4 || result.ready;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;

  assign request.ready = adv1;

  assign ctrl.ld1 = adv1;
  assign ctrl.ld2 = adv2;
  assign ctrl.ld3 = adv3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= request.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  // one lane per date
  dbd_lane u_lane_first (
    .clk     (clk),
    .ctrl    (ctrl),
    .day     (request.first_day),
    .month   (request.first_month),
    .year    (request.first_year),
    .day_num (num_first),
    .ok      (ok_first)
  );

  dbd_lane u_lane_second (
    .clk     (clk),
    .ctrl    (ctrl),
    .day     (request.second_day),
    .month   (request.second_month),
    .year    (request.second_year),
    .day_num (num_second),
    .ok      (ok_second)
  );

  // merge stage doubles as the output register
  dbd_merge u_merge (
    .clk               (clk),
    .load              (adv4),
    .num_first         (num_first),
    .ok_first          (ok_first),
    .num_second        (num_second),
    .ok_second         (ok_second),
    .day_count         (result.day_count),
    .date_error        (result.date_error),
    .second_is_earlier (result.second_is_earlier)
  );

  assign result.valid = v4;

`ifndef ASSERT_OFF
  // any invalid date forces a zero count and no ordering flag
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.date_error != '0)) |->
      (result.day_count == '0) && !result.second_is_earlier)
    else $error("invalid date gave nonzero result");

  // a strictly earlier second date means a nonzero distance
  a_earlier_nonzero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.second_is_earlier) |-> (result.day_count != '0))
    else $error("second_is_earlier with zero count");

  // input only stalls when the output is held
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !request.ready |-> (result.valid && !result.ready))
    else $error("request stalled with output free");

  // a full pipe that is held stays full
  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && v4 && !result.ready) |=> (v1 && v2 && v3 && v4))
    else $error("pipeline lost a request while stalled");
`endif

endmodule
